/* rtl/wildcard_subscription_match_table_macros.svh */
// Assertion macros shared by the checker.
`ifndef WILDCARD_SUBSCRIPTION_MATCH_TABLE_MACROS_SVH
`define WILDCARD_SUBSCRIPTION_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WSMT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsmt assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define WSMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsmt assertion failed");

`endif

/* rtl/wsmt_pkg.sv */
`timescale 1ns / 1ps
package wsmt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 8;
   localparam int MAX_RESULTS = 8;
   localparam int RES_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      FUNC_SUBSCRIBE     = 2'd0,
      FUNC_UNSUBSCRIBE   = 2'd1,
      FUNC_PUBLISH       = 2'd2,
      FUNC_REMOVE_CLIENT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_MISSING   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB_PASS,
      ST_PUB_PASS,
      ST_PUB_FLUSH,
      ST_FIND_PASS,
      ST_MOVE_PASS,
      ST_SNAP_PASS,
      ST_RC_NEXT,
      ST_REPLY
   } state_type;

   // Three topic keys of one subscription
   typedef struct packed {
      logic [31:0] kind;
      logic [31:0] orig;
      logic [31:0] org;
   } topic_type;

   // One table entry as it travels down the ring
   typedef struct packed {
      logic [31:0] client;
      logic [15:0] port;
      topic_type   topic;
   } entry_type;

   // Snapshot lane of one cell: owner hit and its topic keys
   typedef struct packed {
      logic      hit;
      topic_type topic;
   } snap_type;

   // Compare results on the head entry
   typedef struct packed {
      logic owner;
      logic exact;
      logic wild;
   } match_flags_type;

endpackage

/* rtl/wildcard_subscription_match_table.sv */
`timescale 1ns / 1ps
// Channel   | Handshake           | Beat contents
// req       | req_valid/req_stall | func, client key, port, three topic keys
// rsp       | rsp_valid/rsp_stall | status, match flag, client, port, removed count, last
//
// The table is a ring of TABLE_DEPTH cells; one pass rotates it once, one cell a cycle
// (a publish pass holds while a match waits on a stalled rsp); only the head cell is compared.
// Subscribe and publish run one pass; unsubscribe a find pass, then a move pass if found;
// remove-client a snapshot pass, then a find pass per owned entry and a move pass per one found.
// Synchronous active-high reset empties the table; no clearing pass.
// A stalled rsp beat holds; a new req beat is taken once the previous item's last beat is loaded.
module wildcard_subscription_match_table #(
   parameter int TABLE_DEPTH = wsmt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_client_key,
   input  logic [15:0] req_client_port,
   input  logic [31:0] req_type_key,
   input  logic [31:0] req_originator_key,
   input  logic [31:0] req_org_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_has_match,
   output logic [31:0] rsp_match_client,
   output logic [15:0] rsp_match_port,
   output logic [3:0]  rsp_removed_count,
   output logic        rsp_last
);
   import wsmt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
   localparam logic [RES_W-1:0] RES_CAP    = RES_W'(MAX_RESULTS);

   // ring of cells
   entry_type ent_q    [TABLE_DEPTH];
   entry_type ent_next [TABLE_DEPTH];
   snap_type  snap_q   [TABLE_DEPTH];
   snap_type  snap_next[TABLE_DEPTH];
   entry_type ent_tail;
   snap_type  snap_tail;
   logic      ent_shift;
   logic      snap_shift;
   logic      inject;

   // control and request registers
   state_type        state_ff,       state_in;
   logic [IDX_W-1:0] step_ff,        step_in;
   logic [CNT_W-1:0] count_ff,       count_in;
   func_type         func_ff,        func_in;
   logic [31:0]      client_ff,      client_in;
   logic [15:0]      port_ff,        port_in;
   topic_type        key_ff,         key_in;
   entry_type        hold_ff,        hold_in;
   logic             found_ff,       found_in;
   logic [IDX_W-1:0] pos_ff,         pos_in;
   logic [31:0]      pend_client_ff, pend_client_in;
   logic [15:0]      pend_port_ff,   pend_port_in;
   logic             pend_valid_ff,  pend_valid_in;
   logic [RES_W-1:0] nres_ff,        nres_in;
   logic [3:0]       removed_ff,     removed_in;
   logic [IDX_W-1:0] jstep_ff,       jstep_in;
   logic             jdone_ff,       jdone_in;
   status_type       reply_ff,       reply_in;

   // result register
   logic             rsp_valid_ff,   rsp_valid_in;
   status_type       rsp_status_ff,  rsp_status_in;
   logic             rsp_has_ff,     rsp_has_in;
   logic [31:0]      rsp_client_ff,  rsp_client_in;
   logic [15:0]      rsp_port_ff,    rsp_port_in;
   logic [3:0]       rsp_removed_ff, rsp_removed_in;
   logic             rsp_last_ff,    rsp_last_in;

   match_flags_type  flags;
   logic [CNT_W-1:0] step_ext;
   logic             in_range;
   logic             step_last;
   logic             out_free;
   logic             pub_hit;
   logic             exact_hit;
   logic             found_now;
   logic [IDX_W-1:0] step_adv;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k < TABLE_DEPTH - 1) begin : g_link
         assign ent_next[k]  = ent_q[k + 1];
         assign snap_next[k] = snap_q[k + 1];
      end else begin : g_end
         assign ent_next[k]  = ent_tail;
         assign snap_next[k] = snap_tail;
      end

      wsmt_cell u_cell (
         .clock      (clock),
         .ent_shift  (ent_shift),
         .ent_in     (ent_next[k]),
         .ent_out    (ent_q[k]),
         .snap_shift (snap_shift),
         .snap_in    (snap_next[k]),
         .snap_out   (snap_q[k])
      );
   end

   // compare the head entry against the held key
   wsmt_match u_match (
      .head   (ent_q[0]),
      .client (client_ff),
      .port   (port_ff),
      .key    (key_ff),
      .flags  (flags)
   );

   // head leaves cell 0 and re-enters at the tail, or is replaced
   assign ent_tail = inject ? hold_ff : ent_q[0];

   assign step_ext  = CNT_W'(step_ff);
   assign in_range  = step_ext < count_ff;
   assign step_last = step_ff == LAST_STEP;
   assign step_adv  = step_last ? '0 : step_ff + IDX_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pub_hit   = in_range && flags.wild && (nres_ff < RES_CAP);
   assign exact_hit = in_range && flags.exact && !found_ff;
   assign found_now = found_ff || exact_hit;

   // sequencer: next state, ring control, result loads
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      func_in        = func_ff;
      client_in      = client_ff;
      port_in        = port_ff;
      key_in         = key_ff;
      hold_in        = hold_ff;
      found_in       = found_ff;
      pos_in         = pos_ff;
      pend_client_in = pend_client_ff;
      pend_port_in   = pend_port_ff;
      pend_valid_in  = pend_valid_ff;
      nres_in        = nres_ff;
      removed_in     = removed_ff;
      jstep_in       = jstep_ff;
      jdone_in       = jdone_ff;
      reply_in       = reply_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_has_in     = rsp_has_ff;
      rsp_client_in  = rsp_client_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_last_in    = rsp_last_ff;
      ent_shift      = 1'b0;
      snap_shift     = 1'b0;
      inject         = 1'b0;
      snap_tail      = snap_q[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = func_type'(req_func);
               client_in     = req_client_key;
               port_in       = req_client_port;
               key_in.kind   = req_type_key;
               key_in.orig   = req_originator_key;
               key_in.org    = req_org_key;
               hold_in.client     = req_client_key;
               hold_in.port       = req_client_port;
               hold_in.topic.kind = req_type_key;
               hold_in.topic.orig = req_originator_key;
               hold_in.topic.org  = req_org_key;
               step_in       = '0;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               nres_in       = '0;
               removed_in    = '0;
               jstep_in      = '0;
               jdone_in      = 1'b0;
               reply_in      = STATUS_OK;
               unique case (func_type'(req_func))
                  FUNC_SUBSCRIBE: begin
                     if (count_ff == FULL_COUNT) begin
                        reply_in = STATUS_FULL;
                        state_in = ST_REPLY;
                     end else begin
                        state_in = ST_SUB_PASS;
                     end
                  end
                  FUNC_UNSUBSCRIBE: begin
                     state_in = ST_FIND_PASS;
                  end
                  FUNC_PUBLISH: begin
                     if (req_type_key == 32'd0 || req_originator_key == 32'd0 ||
                         req_org_key == 32'd0) begin
                        reply_in = STATUS_MISSING;
                        state_in = ST_REPLY;
                     end else begin
                        state_in = ST_PUB_PASS;
                     end
                  end
                  FUNC_REMOVE_CLIENT: begin
                     state_in = ST_SNAP_PASS;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // append: drop the new entry into the first free slot
         ST_SUB_PASS: begin
            ent_shift = 1'b1;
            inject    = step_ext == count_ff;
            step_in   = step_adv;
            if (step_last) begin
               count_in = count_ff + CNT_W'(1);
               reply_in = STATUS_OK;
               state_in = ST_REPLY;
            end
         end

         // hold one match back so the final one can carry last
         ST_PUB_PASS: begin
            if (!(pub_hit && pend_valid_ff && !out_free)) begin
               ent_shift = 1'b1;
               step_in   = step_adv;
               if (pub_hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_has_in     = 1'b1;
                     rsp_client_in  = pend_client_ff;
                     rsp_port_in    = pend_port_ff;
                     rsp_removed_in = '0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_client_in = ent_q[0].client;
                  pend_port_in   = ent_q[0].port;
                  pend_valid_in  = 1'b1;
                  nres_in        = nres_ff + RES_W'(1);
               end
               if (step_last) begin
                  state_in = ST_PUB_FLUSH;
               end
            end
         end

         ST_PUB_FLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_has_in     = pend_valid_ff;
               rsp_client_in  = pend_valid_ff ? pend_client_ff : 32'd0;
               rsp_port_in    = pend_valid_ff ? pend_port_ff : 16'd0;
               rsp_removed_in = '0;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         // locate the first exact match and capture the last entry
         ST_FIND_PASS: begin
            ent_shift = 1'b1;
            step_in   = step_adv;
            if (exact_hit) begin
               found_in = 1'b1;
               pos_in   = step_ff;
            end
            if (step_ext + CNT_W'(1) == count_ff) begin
               hold_in = ent_q[0];
            end
            if (step_last) begin
               if (found_now) begin
                  state_in = ST_MOVE_PASS;
               end else if (func_ff == FUNC_UNSUBSCRIBE) begin
                  reply_in = STATUS_NOT_FOUND;
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_RC_NEXT;
               end
            end
         end

         // overwrite the removed slot with the last entry
         ST_MOVE_PASS: begin
            ent_shift = 1'b1;
            inject    = step_ff == pos_ff;
            step_in   = step_adv;
            if (step_last) begin
               count_in = count_ff - CNT_W'(1);
               found_in = 1'b0;
               if (func_ff == FUNC_UNSUBSCRIBE) begin
                  reply_in = STATUS_OK;
                  state_in = ST_REPLY;
               end else begin
                  removed_in = (removed_ff == 4'hF) ? removed_ff : removed_ff + 4'd1;
                  state_in   = ST_RC_NEXT;
               end
            end
         end

         // record each owned entry's keys in table order
         ST_SNAP_PASS: begin
            ent_shift       = 1'b1;
            snap_shift      = 1'b1;
            snap_tail.hit   = in_range && flags.owner;
            snap_tail.topic = ent_q[0].topic;
            step_in         = step_adv;
            if (step_last) begin
               jstep_in = '0;
               jdone_in = 1'b0;
               state_in = ST_RC_NEXT;
            end
         end

         // pop the next snapshot slot and remove its entry
         ST_RC_NEXT: begin
            if (jdone_ff) begin
               reply_in = STATUS_OK;
               state_in = ST_REPLY;
            end else begin
               snap_shift    = 1'b1;
               snap_tail.hit = 1'b0;
               jstep_in      = (jstep_ff == LAST_STEP) ? '0 : jstep_ff + IDX_W'(1);
               jdone_in      = jstep_ff == LAST_STEP;
               if (snap_q[0].hit) begin
                  key_in   = snap_q[0].topic;
                  step_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_FIND_PASS;
               end
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = reply_ff;
               rsp_has_in     = 1'b0;
               rsp_client_in  = 32'd0;
               rsp_port_in    = 16'd0;
               rsp_removed_in = removed_ff;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         jdone_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         jdone_ff      <= jdone_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      func_ff        <= func_in;
      client_ff      <= client_in;
      port_ff        <= port_in;
      key_ff         <= key_in;
      hold_ff        <= hold_in;
      pos_ff         <= pos_in;
      pend_client_ff <= pend_client_in;
      pend_port_ff   <= pend_port_in;
      nres_ff        <= nres_in;
      removed_ff     <= removed_in;
      jstep_ff       <= jstep_in;
      reply_ff       <= reply_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_has_ff     <= rsp_has_in;
      rsp_client_ff  <= rsp_client_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_has_match     = rsp_has_ff;
   assign rsp_match_client  = rsp_client_ff;
   assign rsp_match_port    = rsp_port_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* rtl/wsmt_cell.sv */
`timescale 1ns / 1ps
module wsmt_cell (
   input  logic                 clock,
   input  logic                 ent_shift,
   input  wsmt_pkg::entry_type  ent_in,
   output wsmt_pkg::entry_type  ent_out,
   input  logic                 snap_shift,
   input  wsmt_pkg::snap_type   snap_in,
   output wsmt_pkg::snap_type   snap_out
);
   import wsmt_pkg::*;

   entry_type ent_ff;
   snap_type  snap_ff;

   // take the neighbor's entry on each ring step
   always_ff @(posedge clock) begin
      if (ent_shift) begin
         ent_ff <= ent_in;
      end
   end

   // take the neighbor's snapshot slot on each snapshot step
   always_ff @(posedge clock) begin
      if (snap_shift) begin
         snap_ff <= snap_in;
      end
   end

   assign ent_out  = ent_ff;
   assign snap_out = snap_ff;

endmodule

/* rtl/wsmt_match.sv */
`timescale 1ns / 1ps
module wsmt_match (
   input  wsmt_pkg::entry_type        head,
   input  logic [31:0]                client,
   input  logic [15:0]                port,
   input  wsmt_pkg::topic_type        key,
   output wsmt_pkg::match_flags_type  flags
);
   import wsmt_pkg::*;

   logic kind_ok;
   logic orig_ok;
   logic org_ok;

   // stored zero key acts as wildcard
   assign kind_ok = (head.topic.kind == key.kind) || (head.topic.kind == 32'd0);
   assign orig_ok = (head.topic.orig == key.orig) || (head.topic.orig == 32'd0);
   assign org_ok  = (head.topic.org == key.org) || (head.topic.org == 32'd0);

   assign flags.owner = (head.client == client) && (head.port == port);
   assign flags.exact = flags.owner && (head.topic == key);
   assign flags.wild  = kind_ok && orig_ok && org_ok;

endmodule

/* rtl/wsmt_checker.sv */
`timescale 1ns / 1ps
`include "wildcard_subscription_match_table_macros.svh"
module wsmt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_has_match,
   input logic [31:0] rsp_match_client,
   input logic [15:0] rsp_match_port,
   input logic [3:0]  rsp_removed_count,
   input logic        rsp_last
);
   import wsmt_pkg::*;

   // stalled result beat holds
   `WSMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_match_client) && $stable(rsp_match_port) && $stable(rsp_last))

   // a taken request keeps the block busy on the next cycle
   `WSMT_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

   // only publish beats come in runs, and each names a match
   `WSMT_ASSERT_NOW(a_run_is_match, rsp_valid && !rsp_last, rsp_has_match)

   // a match beat is a plain ok with no removal count
   `WSMT_ASSERT_NOW(a_match_ok, rsp_valid && rsp_has_match, rsp_status == STATUS_OK && rsp_removed_count == 4'd0)

   // error beats are single and carry no match
   `WSMT_ASSERT_NOW(a_error_single, rsp_valid && rsp_status != STATUS_OK, rsp_last && !rsp_has_match)

endmodule

bind wildcard_subscription_match_table wsmt_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_has_match     (rsp_has_match),
   .rsp_match_client  (rsp_match_client),
   .rsp_match_port    (rsp_match_port),
   .rsp_removed_count (rsp_removed_count),
   .rsp_last          (rsp_last)
);

/* verif/tb_wildcard_subscription_match_table.sv */
`timescale 1ns / 1ps
module tb_wildcard_subscription_match_table;
   import wsmt_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int LOUD_LIMIT = 40;

   // Directed keys
   localparam bit [31:0] CLIENT_A = 32'h0000_00A1;
   localparam bit [31:0] CLIENT_B = 32'h0000_00B2;
   localparam bit [31:0] TYPE_1 = 32'h0000_1001;
   localparam bit [31:0] ORIG_1 = 32'h0000_2002;
   localparam bit [31:0] ORG_1 = 32'h0000_3003;
   localparam bit [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam bit [15:0] PORT_MAX = 16'hFFFF;

   // One expected reply beat
   typedef struct {
      status_type status;
      bit         has_match;
      bit [31:0]  client;
      bit [15:0]  port;
      bit [3:0]   removed;
      bit         last;
   } reply_type;

   // Subscription table shadow and the reply beats it predicts
   class subscription_scoreboard;
      bit [31:0]   ent_client[DEPTH];
      bit [15:0]   ent_port[DEPTH];
      bit [31:0]   ent_type[DEPTH];
      bit [31:0]   ent_orig[DEPTH];
      bit [31:0]   ent_org[DEPTH];
      int unsigned used;
      reply_type   replies[$];
      int unsigned errors;
      int unsigned n_func[4];
      int unsigned n_hits;
      int unsigned n_full;
      int unsigned n_miss;
      int unsigned n_checked;
      int unsigned max_removed;

      function void push_reply(status_type st, bit hit, bit [31:0] c, bit [15:0] p,
                               int unsigned removed, bit fin);
         reply_type r;
         r.status = st;
         r.has_match = hit;
         r.client = c;
         r.port = p;
         r.removed = (removed > 15) ? 4'd15 : removed[3:0];
         r.last = fin;
         replies.push_back(r);
      endfunction

      function int locate_entry(bit [31:0] c, bit [15:0] p, bit [31:0] t, bit [31:0] o,
                                bit [31:0] g);
         for (int i = 0; i < used; i++) begin
            if (ent_client[i] == c && ent_port[i] == p && ent_type[i] == t &&
                ent_orig[i] == o && ent_org[i] == g) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Move the last entry into the freed slot
      function void drop_entry(int i);
         used--;
         ent_client[i] = ent_client[used];
         ent_port[i] = ent_port[used];
         ent_type[i] = ent_type[used];
         ent_orig[i] = ent_orig[used];
         ent_org[i] = ent_org[used];
      endfunction

      function int unsigned pending();
         return replies.size();
      endfunction

      function void note_request(func_type f, bit [31:0] c, bit [15:0] p, bit [31:0] t,
                                 bit [31:0] o, bit [31:0] g);
         int pos;
         int hits;
         int unsigned removed;
         bit [31:0] snap_t[$];
         bit [31:0] snap_o[$];
         bit [31:0] snap_g[$];
         n_func[f]++;
         case (f)
            FUNC_SUBSCRIBE: begin
               if (used < DEPTH) begin
                  ent_client[used] = c;
                  ent_port[used] = p;
                  ent_type[used] = t;
                  ent_orig[used] = o;
                  ent_org[used] = g;
                  used++;
                  push_reply(STATUS_OK, 1'b0, '0, '0, 0, 1'b1);
               end else begin
                  n_full++;
                  push_reply(STATUS_FULL, 1'b0, '0, '0, 0, 1'b1);
               end
            end
            FUNC_UNSUBSCRIBE: begin
               pos = locate_entry(c, p, t, o, g);
               if (pos < 0) begin
                  n_miss++;
                  push_reply(STATUS_NOT_FOUND, 1'b0, '0, '0, 0, 1'b1);
               end else begin
                  drop_entry(pos);
                  push_reply(STATUS_OK, 1'b0, '0, '0, 0, 1'b1);
               end
            end
            FUNC_PUBLISH: begin
               if (t == 0 || o == 0 || g == 0) begin
                  push_reply(STATUS_MISSING, 1'b0, '0, '0, 0, 1'b1);
               end else begin
                  // Stored zero keys are wildcards; emit in table order
                  hits = 0;
                  for (int i = 0; i < used && hits < MAX_RESULTS; i++) begin
                     if ((ent_type[i] == t || ent_type[i] == 0) &&
                         (ent_orig[i] == o || ent_orig[i] == 0) &&
                         (ent_org[i] == g || ent_org[i] == 0)) begin
                        push_reply(STATUS_OK, 1'b1, ent_client[i], ent_port[i], 0, 1'b0);
                        hits++;
                     end
                  end
                  n_hits += hits;
                  if (hits == 0) begin
                     push_reply(STATUS_OK, 1'b0, '0, '0, 0, 1'b1);
                  end else begin
                     replies[replies.size() - 1].last = 1'b1;
                  end
               end
            end
            default: begin
               // Snapshot the client's entries, then retire them one by one
               for (int i = 0; i < used; i++) begin
                  if (ent_client[i] == c && ent_port[i] == p) begin
                     snap_t.push_back(ent_type[i]);
                     snap_o.push_back(ent_orig[i]);
                     snap_g.push_back(ent_org[i]);
                  end
               end
               removed = 0;
               foreach (snap_t[k]) begin
                  pos = locate_entry(c, p, snap_t[k], snap_o[k], snap_g[k]);
                  if (pos >= 0) begin
                     drop_entry(pos);
                     removed++;
                  end
               end
               if (removed > max_removed) max_removed = removed;
               push_reply(STATUS_OK, 1'b0, '0, '0, removed, 1'b1);
            end
         endcase
      endfunction

      task report(string msg);
         if (errors < LOUD_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_reply(logic [1:0] st, logic hit, logic [31:0] c, logic [15:0] p,
                       logic [3:0] removed, logic fin);
         reply_type want;
         n_checked++;
         if (replies.size() == 0) begin
            report($sformatf("reply beat with none outstanding (status %0d)", st));
            return;
         end
         want = replies.pop_front();
         if (st !== want.status)
            report($sformatf("status %0d, want %0d", st, want.status));
         if (hit !== want.has_match)
            report($sformatf("has_match %0b, want %0b", hit, want.has_match));
         if (c !== want.client)
            report($sformatf("match_client %h, want %h", c, want.client));
         if (p !== want.port)
            report($sformatf("match_port %h, want %h", p, want.port));
         if (removed !== want.removed)
            report($sformatf("removed_count %0d, want %0d", removed, want.removed));
         if (fin !== want.last)
            report($sformatf("last %0b, want %0b", fin, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_SUBSCRIBE;
   logic [31:0] req_client_key = '0;
   logic [15:0] req_client_port = '0;
   logic [31:0] req_type_key = '0;
   logic [31:0] req_originator_key = '0;
   logic [31:0] req_org_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_has_match;
   logic [31:0] rsp_match_client;
   logic [15:0] rsp_match_port;
   logic [3:0]  rsp_removed_count;
   logic        rsp_last;

   subscription_scoreboard sb;

   bit [31:0] topic_pool[6];
   bit [31:0] client_pool[4];
   bit [15:0] port_pool[3];

   int stall_mode = 0;
   int stall_left = 0;

   wildcard_subscription_match_table #(.TABLE_DEPTH(DEPTH)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_client_key     (req_client_key),
      .req_client_port    (req_client_port),
      .req_type_key       (req_type_key),
      .req_originator_key (req_originator_key),
      .req_org_key        (req_org_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_has_match      (rsp_has_match),
      .rsp_match_client   (rsp_match_client),
      .rsp_match_port     (rsp_match_port),
      .rsp_removed_count  (rsp_removed_count),
      .rsp_last           (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stretches of no stall, light stall and heavy stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(10, 120);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // Check every accepted reply beat
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_reply(rsp_status, rsp_has_match, rsp_match_client, rsp_match_port,
                        rsp_removed_count, rsp_last);
      end
   end

   // Drive one request beat and hold it until taken
   task automatic send_item(func_type f, bit [31:0] c, bit [15:0] p, bit [31:0] t,
                            bit [31:0] o, bit [31:0] g);
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= f;
      req_client_key <= c;
      req_client_port <= p;
      req_type_key <= t;
      req_originator_key <= o;
      req_org_key <= g;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0) break;
      end
      sb.note_request(f, c, p, t, o, g);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Mostly pooled keys so entries collide; zero is the wildcard
   function automatic bit [31:0] pick_topic();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return '0;
      if (roll < 90) return topic_pool[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   function automatic bit [31:0] pick_client();
      if ($urandom_range(0, 99) < 85) return client_pool[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   function automatic bit [15:0] pick_port();
      if ($urandom_range(0, 99) < 85) return port_pool[$urandom_range(0, 2)];
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   task automatic random_item();
      int kind;
      int idx;
      bit [31:0] c;
      bit [15:0] p;
      bit [31:0] t;
      bit [31:0] o;
      bit [31:0] g;
      kind = $urandom_range(0, 99);
      c = pick_client();
      p = pick_port();
      t = pick_topic();
      o = pick_topic();
      g = pick_topic();
      if (kind < 35) begin
         send_item(FUNC_SUBSCRIBE, c, p, t, o, g);
      end else if (kind < 55) begin
         // Mostly retire a live subscription
         if (sb.used > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, sb.used - 1);
            c = sb.ent_client[idx];
            p = sb.ent_port[idx];
            t = sb.ent_type[idx];
            o = sb.ent_orig[idx];
            g = sb.ent_org[idx];
         end
         send_item(FUNC_UNSUBSCRIBE, c, p, t, o, g);
      end else if (kind < 90) begin
         // Mostly aim at a live subscription and fill in its wildcards
         if ($urandom_range(0, 6) != 0) begin
            if (sb.used > 0 && $urandom_range(0, 3) != 0) begin
               idx = $urandom_range(0, sb.used - 1);
               t = sb.ent_type[idx];
               o = sb.ent_orig[idx];
               g = sb.ent_org[idx];
            end
            if (t == 0) t = topic_pool[$urandom_range(0, 5)];
            if (o == 0) o = topic_pool[$urandom_range(0, 5)];
            if (g == 0) g = topic_pool[$urandom_range(0, 5)];
         end
         send_item(FUNC_PUBLISH, c, p, t, o, g);
      end else begin
         if (sb.used > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, sb.used - 1);
            c = sb.ent_client[idx];
            p = sb.ent_port[idx];
         end
         send_item(FUNC_REMOVE_CLIENT, c, p, t, o, g);
      end
   endtask

   initial begin
      int burst;
      sb = new();
      topic_pool[0] = ALL_ONES;
      topic_pool[1] = TYPE_1;
      topic_pool[2] = ORIG_1;
      topic_pool[3] = ORG_1;
      topic_pool[4] = $urandom() | 32'h100;
      topic_pool[5] = $urandom() | 32'h100;
      client_pool[0] = '0;
      client_pool[1] = ALL_ONES;
      client_pool[2] = CLIENT_A;
      client_pool[3] = $urandom();
      port_pool[0] = '0;
      port_pool[1] = PORT_MAX;
      port_pool[2] = 16'($urandom_range(1, 16'hFFFE));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: no match, not found, nothing removed, missing keys
      send_item(FUNC_PUBLISH, CLIENT_A, 16'd1, TYPE_1, ORIG_1, ORG_1);
      send_item(FUNC_UNSUBSCRIBE, CLIENT_A, 16'd1, TYPE_1, '0, '0);
      send_item(FUNC_REMOVE_CLIENT, CLIENT_A, 16'd1, '0, '0, '0);
      send_item(FUNC_PUBLISH, CLIENT_A, 16'd1, '0, ORIG_1, ORG_1);
      send_item(FUNC_PUBLISH, CLIENT_A, 16'd1, TYPE_1, '0, ORG_1);
      send_item(FUNC_PUBLISH, CLIENT_A, 16'd1, TYPE_1, ORIG_1, '0);
      pause(3);

      // Fill the table, with a duplicate entry and mixed wildcards
      send_item(FUNC_SUBSCRIBE, ALL_ONES, PORT_MAX, ALL_ONES, ALL_ONES, ALL_ONES);
      send_item(FUNC_SUBSCRIBE, '0, '0, '0, '0, '0);
      send_item(FUNC_SUBSCRIBE, CLIENT_A, 16'd1, TYPE_1, '0, '0);
      send_item(FUNC_SUBSCRIBE, CLIENT_A, 16'd1, '0, ORIG_1, '0);
      send_item(FUNC_SUBSCRIBE, CLIENT_A, 16'd1, TYPE_1, ORIG_1, ORG_1);
      send_item(FUNC_SUBSCRIBE, CLIENT_A, 16'd1, TYPE_1, '0, '0);
      send_item(FUNC_SUBSCRIBE, CLIENT_B, 16'd2, '0, '0, ORG_1);
      send_item(FUNC_SUBSCRIBE, CLIENT_A, 16'd2, TYPE_1, ORIG_1, '0);
      send_item(FUNC_SUBSCRIBE, CLIENT_B, 16'd3, TYPE_1, ORIG_1, ORG_1);
      pause(2);

      // Fan-out, removals and compaction
      send_item(FUNC_PUBLISH, '0, '0, TYPE_1, ORIG_1, ORG_1);
      send_item(FUNC_PUBLISH, '0, '0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_item(FUNC_UNSUBSCRIBE, CLIENT_A, 16'd1, '0, ORIG_1, '0);
      send_item(FUNC_UNSUBSCRIBE, CLIENT_A, 16'd7, TYPE_1, ORIG_1, ORG_1);
      send_item(FUNC_REMOVE_CLIENT, CLIENT_A, 16'd1, '0, '0, '0);
      send_item(FUNC_PUBLISH, '0, '0, TYPE_1, ORIG_1, ORG_1);
      send_item(FUNC_REMOVE_CLIENT, CLIENT_B, 16'd2, '0, '0, '0);
      send_item(FUNC_REMOVE_CLIENT, ALL_ONES, PORT_MAX, '0, '0, '0);

      // Random traffic in bursts
      burst = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst == 0) begin
            pause($urandom_range(1, 15));
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
         end
         burst--;
         random_item();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then let the block settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("requests: %0d subscribe, %0d unsubscribe, %0d publish, %0d remove-client",
               sb.n_func[FUNC_SUBSCRIBE], sb.n_func[FUNC_UNSUBSCRIBE],
               sb.n_func[FUNC_PUBLISH], sb.n_func[FUNC_REMOVE_CLIENT]);
      $display("%0d reply beats checked, publish hits %0d, full rejects %0d,",
               sb.n_checked, sb.n_hits, sb.n_full);
      $display("unsubscribe misses %0d, largest client purge %0d",
               sb.n_miss, sb.max_removed);
      if (sb.errors == 0) begin
         $display("tb_wildcard_subscription_match_table: PASS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("tb_wildcard_subscription_match_table: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("watchdog expired with %0d reply beats outstanding", sb.pending());
      $display("tb_wildcard_subscription_match_table: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/wsmt_pkg.sv
rtl/wsmt_cell.sv
rtl/wsmt_match.sv
rtl/wildcard_subscription_match_table.sv
rtl/wsmt_checker.sv
verif/tb_wildcard_subscription_match_table.sv
